FILE: sv/plic_line_reconstruction_2d_defines.svh
// Assertion helpers for the line reconstruction top module
`ifndef PLIC_LINE_RECONSTRUCTION_2D_DEFINES_SVH
`define PLIC_LINE_RECONSTRUCTION_2D_DEFINES_SVH

// check that cond holds whenever trig holds, on the same edge
`define PLR_ASSERT_IMPL(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("plr check failed");

// check that cond holds on every edge out of reset
`define PLR_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("plr check failed");

`endif

FILE: sv/plr_pkg.sv
package plr_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IW = 17;
  localparam int TW = 20;
  localparam int VW = FRAC_BITS + 1;
  localparam int GW = FRAC_BITS + 3;
  localparam int DW = FRAC_BITS + 1;
  localparam int SW = FRAC_BITS + 1;
  localparam int PW = 2 * SW;
  localparam int NW = FRAC_BITS + 2;
  localparam logic [31:0] ONE32 = 32'(1) << FRAC_BITS;
  localparam logic [VW-1:0] ONE = VW'(ONE32);

  typedef enum logic [1:0] {
    CLS_LO,
    CLS_MID,
    CLS_HI
  } cls_t;

  typedef struct packed {
    logic [TW-1:0] tag;
    logic [IW-1:0] sw;
    logic [IW-1:0] w;
    logic [IW-1:0] nw;
    logic [IW-1:0] s;
    logic [IW-1:0] c;
    logic [IW-1:0] n;
    logic [IW-1:0] se;
    logic [IW-1:0] e;
    logic [IW-1:0] ne;
  } vof_in_t;

  typedef struct packed {
    logic [TW-1:0] tag;
    logic [VW-1:0] c;
    logic          xneg;
    logic          zneg;
    logic          x_big;
    logic          flat;
  } side_t;

  typedef struct packed {
    side_t         sd;
    logic [VW-1:0] m;
    cls_t          cls;
  } sq_side_t;

  function automatic logic [VW-1:0] sat(input logic [IW-1:0] raw);
    logic [31:0] r32;
    r32 = 32'(raw);
    return (r32 > ONE32) ? ONE : VW'(r32);
  endfunction

endpackage

FILE: sv/plr_grad.sv
module plr_grad (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_vld,
  output logic                  in_rdy,
  input  plr_pkg::vof_in_t      in_d,
  output logic                  out_vld,
  input  logic                  out_rdy,
  output logic [plr_pkg::GW-1:0] out_small,
  output logic [plr_pkg::GW-1:0] out_big,
  output plr_pkg::side_t        out_side
);
  import plr_pkg::*;

  logic [VW-1:0] sw, w, nw, s, c, n, se, e, ne;
  logic [GW-1:0] wsum, esum, ssum, nsum, ax, az;
  logic          xneg, zneg, xbig;
  logic          vld_r;
  logic [GW-1:0] small_r, big_r;
  side_t         side_r;

  always_comb begin
    sw = sat(in_d.sw);
    w  = sat(in_d.w);
    nw = sat(in_d.nw);
    s  = sat(in_d.s);
    c  = sat(in_d.c);
    n  = sat(in_d.n);
    se = sat(in_d.se);
    e  = sat(in_d.e);
    ne = sat(in_d.ne);
    wsum = GW'(sw) + (GW'(w) << 1) + GW'(nw);
    esum = GW'(se) + (GW'(e) << 1) + GW'(ne);
    ssum = GW'(sw) + (GW'(s) << 1) + GW'(se);
    nsum = GW'(nw) + (GW'(n) << 1) + GW'(ne);
    xneg = esum > wsum;
    zneg = nsum > ssum;
    ax = xneg ? esum - wsum : wsum - esum;
    az = zneg ? nsum - ssum : ssum - nsum;
    xbig = ax >= az;
  end

  assign in_rdy = !vld_r || out_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_rdy) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_vld) begin
      small_r      <= xbig ? az : ax;
      big_r        <= xbig ? ax : az;
      side_r.tag   <= in_d.tag;
      side_r.c     <= c;
      side_r.xneg  <= xneg;
      side_r.zneg  <= zneg;
      side_r.x_big <= xbig;
      side_r.flat  <= (ax == '0) && (az == '0);
    end
  end

  assign out_vld   = vld_r;
  assign out_small = small_r;
  assign out_big   = big_r;
  assign out_side  = side_r;
endmodule

FILE: sv/plr_div.sv
module plr_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  output logic                   in_rdy,
  input  logic [plr_pkg::GW-1:0] in_num,
  input  logic [plr_pkg::GW-1:0] in_den,
  input  plr_pkg::side_t         in_side,
  output logic                   out_vld,
  input  logic                   out_rdy,
  output logic [plr_pkg::DW-1:0] out_q,
  output plr_pkg::side_t         out_side
);
  import plr_pkg::*;

  logic          vld_r  [DW];
  logic          en     [DW];
  logic [GW:0]   rem_r  [DW];
  logic [DW-1:0] q_r    [DW];
  logic [GW-1:0] den_r  [DW];
  side_t         side_r [DW];

  for (genvar k = 0; k < DW; k++) begin : g_st
    logic [GW:0]   rin, rsh, rout;
    logic [DW-1:0] qin;
    logic [GW-1:0] din;
    side_t         sin;
    logic          vin, ge, nxt_rdy;

    if (k == 0) begin : g_first
      assign rin = {1'b0, in_num};
      assign rsh = rin;
      assign qin = '0;
      assign din = in_den;
      assign sin = in_side;
      assign vin = in_vld;
    end else begin : g_rest
      assign rin = rem_r[k-1];
      assign rsh = {rin[GW-1:0], 1'b0};
      assign qin = q_r[k-1];
      assign din = den_r[k-1];
      assign sin = side_r[k-1];
      assign vin = vld_r[k-1];
    end

    if (k == DW - 1) begin : g_last
      assign nxt_rdy = out_rdy;
    end else begin : g_mid
      assign nxt_rdy = en[k+1];
    end

    assign ge   = rsh >= {1'b0, din};
    assign rout = ge ? rsh - {1'b0, din} : rsh;
    assign en[k] = !vld_r[k] || nxt_rdy;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en[k]) begin
        vld_r[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k] && vin) begin
        rem_r[k]  <= rout;
        q_r[k]    <= {qin[DW-2:0], ge};
        den_r[k]  <= din;
        side_r[k] <= sin;
      end
    end
  end

  assign in_rdy   = en[0];
  assign out_vld  = vld_r[DW-1];
  assign out_q    = q_r[DW-1];
  assign out_side = side_r[DW-1];
endmodule

FILE: sv/plr_sqrt.sv
module plr_sqrt (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  output logic                   in_rdy,
  input  logic [plr_pkg::PW-1:0] in_v,
  input  plr_pkg::sq_side_t      in_side,
  output logic                   out_vld,
  input  logic                   out_rdy,
  output logic [plr_pkg::SW-1:0] out_root,
  output plr_pkg::sq_side_t      out_side
);
  import plr_pkg::*;

  logic          vld_r  [SW];
  logic          en     [SW];
  logic [SW+1:0] rem_r  [SW];
  logic [SW-1:0] root_r [SW];
  logic [PW-1:0] v_r    [SW];
  sq_side_t      side_r [SW];

  for (genvar k = 0; k < SW; k++) begin : g_st
    logic [SW+1:0] rin;
    logic [SW+3:0] rsh, trial, rout;
    logic [SW-1:0] root_in;
    logic [PW-1:0] vin_d;
    sq_side_t      sin;
    logic          vin, ge, nxt_rdy;

    if (k == 0) begin : g_first
      assign rin     = '0;
      assign root_in = '0;
      assign vin_d   = in_v;
      assign sin     = in_side;
      assign vin     = in_vld;
    end else begin : g_rest
      assign rin     = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign vin_d   = v_r[k-1];
      assign sin     = side_r[k-1];
      assign vin     = vld_r[k-1];
    end

    if (k == SW - 1) begin : g_last
      assign nxt_rdy = out_rdy;
    end else begin : g_mid
      assign nxt_rdy = en[k+1];
    end

    assign rsh   = {rin, vin_d[PW-1-2*k -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign ge    = rsh >= trial;
    assign rout  = ge ? rsh - trial : rsh;
    assign en[k] = !vld_r[k] || nxt_rdy;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en[k]) begin
        vld_r[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k] && vin) begin
        rem_r[k]  <= rout[SW+1:0];
        root_r[k] <= {root_in[SW-2:0], ge};
        v_r[k]    <= vin_d;
        side_r[k] <= sin;
      end
    end
  end

  assign in_rdy   = en[0];
  assign out_vld  = vld_r[SW-1];
  assign out_root = root_r[SW-1];
  assign out_side = side_r[SW-1];
endmodule

FILE: sv/plic_line_reconstruction_2d.sv
// Register stages from an accepted input word to its result word
// (1 gradient stage, 17 divider stages, 1 multiply stage, 17 root stages, 1 output).
// Throughput: one word per cycle unless the output stalls; the divider and root pipelines retire one bit per stage.
// Stalls propagate stage by stage, so empty stages keep filling under output backpressure.
// Reset (rst_n low, synchronous) clears all valid bits; the data registers are not reset.
module plic_line_reconstruction_2d (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [19:0]                 in_cell_tag,
  input  logic [16:0]                 in_vof_sw,
  input  logic [16:0]                 in_vof_w,
  input  logic [16:0]                 in_vof_nw,
  input  logic [16:0]                 in_vof_s,
  input  logic [16:0]                 in_vof_center,
  input  logic [16:0]                 in_vof_n,
  input  logic [16:0]                 in_vof_se,
  input  logic [16:0]                 in_vof_e,
  input  logic [16:0]                 in_vof_ne,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [19:0]                 out_tag_out,
  output logic signed [17:0]          out_normal_x,
  output logic signed [17:0]          out_normal_z,
  output logic [17:0]                 out_line_alpha
);
  import plr_pkg::*;
  `include "plic_line_reconstruction_2d_defines.svh"

  vof_in_t       in_d;
  logic          g_vld, g_rdy, d_vld, d_rdy, s_vld, s_rdy;
  logic [GW-1:0] g_small, g_big;
  side_t         g_side, d_side;
  logic [DW-1:0] d_q;
  logic [VW-1:0] m, cp;
  logic [VW:0]   c2;
  cls_t          cls;
  logic [PW-1:0] prod;
  logic          p_vld_r, p_en, o_en;
  logic [PW-1:0] p_prod_r;
  sq_side_t      p_side_r, s_side;
  logic [SW-1:0] s_root;
  logic [VW-1:0] mx, mz;
  logic [NW-1:0] nx, nz, alpha;
  logic          o_vld_r;
  logic [TW-1:0] o_tag_r;
  logic [NW-1:0] o_nx_r, o_nz_r, o_alpha_r;

  assign in_d = '{tag: in_cell_tag, sw: in_vof_sw, w: in_vof_w, nw: in_vof_nw,
                  s: in_vof_s, c: in_vof_center, n: in_vof_n, se: in_vof_se,
                  e: in_vof_e, ne: in_vof_ne};

  plr_grad u_grad (
    .clk, .rst_n,
    .in_vld(in_valid), .in_rdy(in_ready), .in_d,
    .out_vld(g_vld), .out_rdy(g_rdy),
    .out_small(g_small), .out_big(g_big), .out_side(g_side)
  );

  plr_div u_div (
    .clk, .rst_n,
    .in_vld(g_vld), .in_rdy(g_rdy),
    .in_num(g_small), .in_den(g_big), .in_side(g_side),
    .out_vld(d_vld), .out_rdy(d_rdy),
    .out_q(d_q), .out_side(d_side)
  );

  always_comb begin
    m  = d_side.flat ? ONE : VW'(d_q);
    c2 = {d_side.c, 1'b0};
    if (c2 <= {1'b0, m}) begin
      cls = CLS_LO;
    end else if (c2 <= {ONE, 1'b0} - {1'b0, m}) begin
      cls = CLS_MID;
    end else begin
      cls = CLS_HI;
    end
    cp   = (cls == CLS_LO) ? d_side.c : ONE - d_side.c;
    prod = (PW'(cp) * PW'(m)) << 1;
  end

  assign p_en  = !p_vld_r || s_rdy;
  assign d_rdy = p_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else if (p_en) begin
      p_vld_r <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (p_en && d_vld) begin
      p_prod_r     <= prod;
      p_side_r.sd  <= d_side;
      p_side_r.m   <= m;
      p_side_r.cls <= cls;
    end
  end

  plr_sqrt u_sqrt (
    .clk, .rst_n,
    .in_vld(p_vld_r), .in_rdy(s_rdy),
    .in_v(p_prod_r), .in_side(p_side_r),
    .out_vld(s_vld), .out_rdy(o_en),
    .out_root(s_root), .out_side(s_side)
  );

  always_comb begin
    mx = s_side.sd.x_big ? ONE : s_side.m;
    mz = s_side.sd.x_big ? s_side.m : ONE;
    if (s_side.sd.flat) begin
      nx = '0;
      nz = '0;
    end else begin
      nx = s_side.sd.xneg ? NW'(0) - NW'(mx) : NW'(mx);
      nz = s_side.sd.zneg ? NW'(0) - NW'(mz) : NW'(mz);
    end
    case (s_side.cls)
      CLS_LO:  alpha = NW'(s_root);
      CLS_MID: alpha = NW'(s_side.sd.c) + NW'(s_side.m >> 1);
      CLS_HI:  alpha = NW'(s_side.m) + NW'(ONE) - NW'(s_root);
      default: alpha = '0;
    endcase
  end

  assign o_en = !o_vld_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (o_en) begin
      o_vld_r <= s_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (o_en && s_vld) begin
      o_tag_r   <= s_side.sd.tag;
      o_nx_r    <= nx;
      o_nz_r    <= nz;
      o_alpha_r <= alpha;
    end
  end

  assign out_valid      = o_vld_r;
  assign out_tag_out    = o_tag_r;
  assign out_normal_x   = o_nx_r;
  assign out_normal_z   = o_nz_r;
  assign out_line_alpha = o_alpha_r;

  `PLR_ASSERT_IMPL(a_alpha_range, out_valid, out_line_alpha <= NW'({ONE, 1'b0}))
  `PLR_ASSERT_IMPL(a_unit_normal, out_valid && (out_normal_x != '0 || out_normal_z != '0),
    out_normal_x == NW'(ONE) || out_normal_x == -NW'(ONE) ||
    out_normal_z == NW'(ONE) || out_normal_z == -NW'(ONE))
  `PLR_ASSERT_ALWAYS(a_stall_cause, in_ready || out_valid)
endmodule
